### design/itra_pkg.sv
// Shared types, constants and a helper function for the integer to ASCII converter.
`timescale 1ns / 1ps

package itra_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int RADIX_W     = 6;
   localparam int CHAR_W      = 8;
   localparam int RADIX_MIN   = 2;
   localparam int RADIX_MAX   = 36;
   localparam int RADIX_DEC   = 10;
   localparam int DIGIT_NINE  = 9;
   localparam int STEP_BITS   = 4;
   localparam int DIV_CYCLES  = VALUE_BITS / STEP_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
   localparam int DIGIT_CNT_W = $clog2(VALUE_BITS + 1);
   localparam int DIGIT_IDX_W = $clog2(VALUE_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A_LC  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NULL  = 8'h00;

   typedef enum logic [1:0] {
      KIND_BAD  = 2'd0,
      KIND_ZERO = 2'd1,
      KIND_NUM  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic                    neg;
      logic [VALUE_BITS-1:0]   mag;
      logic [RADIX_W-1:0]      radix;
   } job_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = CHAR_W'(d);
      if (d > RADIX_W'(DIGIT_NINE)) begin
         digit_to_char = d_ext - CHAR_W'(RADIX_DEC) + CHAR_A_LC;
      end else begin
         digit_to_char = d_ext + CHAR_ZERO;
      end
   endfunction

endpackage

### design/itra_front.sv
// Front stage: accepts a conversion request, classifies it and hands it to the queue.
`timescale 1ns / 1ps

module itra_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic signed [itra_pkg::VALUE_BITS-1:0]   req_value,
   input  logic        [itra_pkg::RADIX_W-1:0]      req_radix,
   input  logic                                     queue_full,
   output logic                                     busy,
   output logic                                     push,
   output itra_pkg::job_type                        push_job
);

   logic                 valid_ff;
   logic                 valid_in;
   itra_pkg::job_type    job_ff;
   itra_pkg::job_type    job_in;
   itra_pkg::job_type    classified;
   logic                 accept;
   logic [itra_pkg::VALUE_BITS-1:0] raw;

   assign push   = valid_ff && !queue_full;
   assign busy   = valid_ff && queue_full;
   assign accept = start && !busy;
   assign push_job = job_ff;

   always_comb begin
      raw = itra_pkg::VALUE_BITS'(req_value);
      classified.radix = req_radix;
      classified.neg   = 1'b0;
      classified.mag   = raw;
      if (req_radix < itra_pkg::RADIX_W'(itra_pkg::RADIX_MIN) ||
          req_radix > itra_pkg::RADIX_W'(itra_pkg::RADIX_MAX)) begin
         classified.kind = itra_pkg::KIND_BAD;
      end else if (raw == '0) begin
         classified.kind = itra_pkg::KIND_ZERO;
      end else begin
         classified.kind = itra_pkg::KIND_NUM;
         if (req_radix == itra_pkg::RADIX_W'(itra_pkg::RADIX_DEC) &&
             raw[itra_pkg::VALUE_BITS-1]) begin
            classified.neg = 1'b1;
            classified.mag = itra_pkg::VALUE_BITS'(~raw + 1'b1);
         end
      end
   end

   always_comb begin
      valid_in = accept || (valid_ff && !push);
      job_in   = accept ? classified : job_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

### design/itra_queue.sv
// Short queue of classified requests between the front and back stages.
`timescale 1ns / 1ps

module itra_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  itra_pkg::job_type   push_job,
   input  logic                pop,
   output itra_pkg::job_type   pop_job,
   output logic                full,
   output logic                empty
);

   itra_pkg::job_type                  slot_ff [itra_pkg::QUEUE_DEPTH];
   logic [itra_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [itra_pkg::QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [itra_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [itra_pkg::QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [itra_pkg::QUEUE_CNT_W-1:0]   count_ff;
   logic [itra_pkg::QUEUE_CNT_W-1:0]   count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full    = (count_ff == itra_pkg::QUEUE_CNT_W'(itra_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? itra_pkg::QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? itra_pkg::QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = itra_pkg::QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = itra_pkg::QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/itra_back.sv
// Back stage: divides out the digits, stacks them and emits the characters.
`timescale 1ns / 1ps

module itra_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                queue_empty,
   input  itra_pkg::job_type                   queue_job,
   output logic                                pop,
   output logic                                rsp_valid,
   output logic [itra_pkg::CHAR_W-1:0]         rsp_char_code,
   output logic                                rsp_last_char,
   output logic                                rsp_bad_radix
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_SIGN  = 4'b0100,
      ST_DIGIT = 4'b1000
   } state_type;

   state_type                            state_ff;
   state_type                            state_in;
   logic [itra_pkg::VALUE_BITS-1:0]      quo_ff;
   logic [itra_pkg::VALUE_BITS-1:0]      quo_in;
   logic [itra_pkg::RADIX_W-1:0]         rem_ff;
   logic [itra_pkg::RADIX_W-1:0]         rem_in;
   logic [itra_pkg::RADIX_W-1:0]         radix_ff;
   logic [itra_pkg::RADIX_W-1:0]         radix_in;
   logic                                 neg_ff;
   logic                                 neg_in;
   logic [itra_pkg::DIV_CNT_W-1:0]       cnt_ff;
   logic [itra_pkg::DIV_CNT_W-1:0]       cnt_in;
   logic [itra_pkg::DIGIT_CNT_W-1:0]     nd_ff;
   logic [itra_pkg::DIGIT_CNT_W-1:0]     nd_in;
   logic [itra_pkg::RADIX_W-1:0]         stack_ff [itra_pkg::VALUE_BITS];
   logic                                 stack_we;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [itra_pkg::CHAR_W-1:0]          rsp_char_ff;
   logic [itra_pkg::CHAR_W-1:0]          rsp_char_in;
   logic                                 rsp_last_ff;
   logic                                 rsp_last_in;
   logic                                 rsp_bad_ff;
   logic                                 rsp_bad_in;
   logic [itra_pkg::VALUE_BITS-1:0]      step_quo;
   logic [itra_pkg::RADIX_W-1:0]         step_rem;
   logic [itra_pkg::RADIX_W:0]           trial;
   logic [itra_pkg::DIGIT_CNT_W-1:0]     nd_dec;
   logic [itra_pkg::RADIX_W-1:0]         top_digit;

   assign pop           = (state_ff == ST_IDLE) && !queue_empty;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;
   assign rsp_bad_radix = rsp_bad_ff;
   assign nd_dec        = itra_pkg::DIGIT_CNT_W'(nd_ff - 1'b1);
   assign top_digit     = stack_ff[nd_dec[itra_pkg::DIGIT_IDX_W-1:0]];

   // Restoring division, several quotient bits per cycle.
   always_comb begin
      step_quo = quo_ff;
      step_rem = rem_ff;
      trial    = '0;
      for (int i = 0; i < itra_pkg::STEP_BITS; i++) begin
         trial    = {step_rem, step_quo[itra_pkg::VALUE_BITS-1]};
         step_quo = {step_quo[itra_pkg::VALUE_BITS-2:0], 1'b0};
         if (trial >= {1'b0, radix_ff}) begin
            trial       = trial - {1'b0, radix_ff};
            step_quo[0] = 1'b1;
         end
         step_rem = trial[itra_pkg::RADIX_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      nd_in        = nd_ff;
      stack_we     = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               case (queue_job.kind)
                  itra_pkg::KIND_BAD: begin
                     rsp_valid_in = 1'b1;
                     rsp_char_in  = itra_pkg::CHAR_NULL;
                     rsp_last_in  = 1'b1;
                     rsp_bad_in   = 1'b1;
                  end
                  itra_pkg::KIND_ZERO: begin
                     rsp_valid_in = 1'b1;
                     rsp_char_in  = itra_pkg::CHAR_ZERO;
                     rsp_last_in  = 1'b1;
                     rsp_bad_in   = 1'b0;
                  end
                  default: begin
                     quo_in   = queue_job.mag;
                     rem_in   = '0;
                     radix_in = queue_job.radix;
                     neg_in   = queue_job.neg;
                     cnt_in   = '0;
                     nd_in    = '0;
                     state_in = ST_DIV;
                  end
               endcase
            end
         end
         ST_DIV: begin
            quo_in = step_quo;
            rem_in = step_rem;
            cnt_in = itra_pkg::DIV_CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == itra_pkg::DIV_CNT_W'(itra_pkg::DIV_CYCLES - 1)) begin
               stack_we = 1'b1;
               nd_in    = itra_pkg::DIGIT_CNT_W'(nd_ff + 1'b1);
               rem_in   = '0;
               if (step_quo == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_DIGIT;
               end
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = itra_pkg::CHAR_MINUS;
            rsp_last_in  = 1'b0;
            rsp_bad_in   = 1'b0;
            state_in     = ST_DIGIT;
         end
         ST_DIGIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = itra_pkg::digit_to_char(top_digit);
            rsp_last_in  = (nd_dec == '0);
            rsp_bad_in   = 1'b0;
            nd_in        = nd_dec;
            if (nd_dec == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      nd_ff       <= nd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
      if (stack_we) begin
         stack_ff[nd_ff[itra_pkg::DIGIT_IDX_W-1:0]] <= step_rem;
      end
   end

endmodule

### design/integer_to_radix_ascii_core.sv
// Top level of the integer to radix ASCII converter.
`timescale 1ns / 1ps

// Converts a 32-bit value to ASCII digits in a base from 2 to 36 (signed in
// base 10, else taken as unsigned), most significant digit first, one
// character per cycle on the rsp_ ports with rsp_valid as strobe and
// rsp_last_char on the final one; the receiver cannot stall, so characters
// arrive back to back. A request is taken when start is high and busy is low;
// the front register and a two-entry queue let up to three requests wait while
// one is converted. Each digit costs one full pass of the divider, which
// retires four quotient bits per cycle over the 32-bit value, and each
// character is then emitted from the digit stack. Zero and a bad radix give
// their single result without using the divider.
module integer_to_radix_ascii_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [itra_pkg::VALUE_BITS-1:0]   req_value,
   input  logic        [itra_pkg::RADIX_W-1:0]      req_radix,
   output logic                                     rsp_valid,
   output logic        [itra_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                                     rsp_last_char,
   output logic                                     rsp_bad_radix
);

   logic                 queue_full;
   logic                 queue_empty;
   logic                 push;
   logic                 pop;
   itra_pkg::job_type    push_job;
   itra_pkg::job_type    pop_job;

   itra_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_value  (req_value),
      .req_radix  (req_radix),
      .queue_full (queue_full),
      .busy       (busy),
      .push       (push),
      .push_job   (push_job)
   );

   itra_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   itra_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .queue_job     (pop_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char),
      .rsp_bad_radix (rsp_bad_radix)
   );

endmodule

### design/itra_checker.sv
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps

module itra_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     rsp_valid,
   input  logic [itra_pkg::CHAR_W-1:0]              rsp_char_code,
   input  logic                                     rsp_last_char,
   input  logic                                     rsp_bad_radix
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result transfer right after reset.");

   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_radix |-> rsp_last_char &&
                                     rsp_char_code == itra_pkg::CHAR_NULL)
      else $error("Error result is not a single null character.");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_char |=> rsp_valid && !rsp_bad_radix)
      else $error("Gap inside a conversion.");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_radix |->
         (rsp_char_code >= 8'h30 && rsp_char_code <= 8'h39) ||
         (rsp_char_code >= 8'h61 && rsp_char_code <= 8'h7A) ||
         rsp_char_code == itra_pkg::CHAR_MINUS)
      else $error("Character outside the digit set.");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == itra_pkg::CHAR_MINUS |-> !rsp_last_char)
      else $error("Sign marked as final character.");

endmodule

bind integer_to_radix_ascii_core itra_checker u_itra_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_char_code (rsp_char_code),
   .rsp_last_char (rsp_last_char),
   .rsp_bad_radix (rsp_bad_radix)
);
